### rtl/core/ppdc_pkg.sv
package ppdc_pkg;

    // Frame layout constants.
    localparam logic [7:0] SYNC_B0 = 8'hAA;
    localparam logic [7:0] SYNC_B1 = 8'h55;
    localparam logic [7:0] SYNC_B2 = 8'hCC;
    localparam logic [7:0] SYNC_B3 = 8'h33;
    localparam logic [7:0] CMD_B0  = 8'hAC;
    localparam logic [7:0] CMD_B1  = 8'hC9;

    // Header plus CRC bytes counted in the total length field.
    localparam int unsigned HDR_LEN     = 12;
    localparam int unsigned MAX_PAYLOAD = 512;
    localparam int unsigned LEFT_W      = 10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SYNC = 3'd1,
        ST_BAD_CMD  = 3'd2,
        ST_BAD_ZERO = 3'd3,
        ST_BAD_IDX  = 3'd4,
        ST_BAD_LEN  = 3'd5,
        ST_BAD_CRC  = 3'd6
    } status_t;

endpackage

### rtl/core/photo_packet_deframer_crc16.sv
// Path: a beat accepted on the slave side sits in the input register, and the
// parser step then loads its result, if any, into the result register that
// drives the master side.
// Rate: one beat per cycle while the master side does not stall; the byte-wise
// CRC and field checks are combinational between the two registers.
// Reset: rst_n is asynchronous, active low; it starts sync hunting, sets the
// expected packet index to 1 and empties both registers.
module photo_packet_deframer_crc16
    import ppdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [10:8] status,
                                   // [18:11] packet_index, [23:19] zero
    output logic        m_tuser    // [0] is_status
);

    // Parser phases. Codes 13 to 15 have no meaning and fall back to hunting.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_SYNC2 = 4'd2,
        PH_SYNC3 = 4'd3,
        PH_LENH  = 4'd4,
        PH_LENL  = 4'd5,
        PH_CMD0  = 4'd6,
        PH_CMD1  = 4'd7,
        PH_ZERO  = 4'd8,
        PH_INDEX = 4'd9,
        PH_DATA  = 4'd10,
        PH_CRCH  = 4'd11,
        PH_CRCL  = 4'd12
    } phase_t;

    // Input register.
    logic        in_valid_reg;
    logic        in_mode_reg;
    logic [7:0]  in_byte_reg;

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          index_reg, index_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    logic [7:0]          crc_hi_reg, crc_hi_next;
    logic [1:0]          skip_reg, skip_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_is_stat_reg;
    status_t     out_status_reg;
    logic [7:0]  out_index_reg;

    logic        process;
    logic        emit;
    logic [7:0]  emit_data;
    logic        emit_is_stat;
    status_t     emit_status;
    logic [15:0] crc_fed;
    logic [15:0] total;
    logic [15:0] rx_crc;

    // The parser step fires when an input beat is held and the result register
    // is free or is being drained in this cycle.
    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    ppdc_crc_step u_crc
    (
        .crc_in  ((phase_reg == PH_HUNT) ? CRC_INIT : crc_reg),
        .data    (in_byte_reg),
        .crc_out (crc_fed)
    );

    assign total  = {len_hi_reg, in_byte_reg};
    assign rx_crc = {crc_hi_reg, in_byte_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        index_next   = index_reg;
        len_hi_next  = len_hi_reg;
        crc_hi_next  = crc_hi_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        emit_data    = 8'h00;
        emit_is_stat = 1'b0;
        emit_status  = ST_OK;

        if (in_mode_reg)
        begin
            // A new transfer drops any frame in progress without a result.
            phase_next = PH_HUNT;
            index_next = 8'd1;
            left_next  = '0;
            skip_next  = 2'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte_reg == SYNC_B0)
                    begin
                        crc_next   = crc_fed;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_SYNC1, PH_SYNC2, PH_SYNC3:
                begin
                    if ((phase_reg == PH_SYNC1 && in_byte_reg != SYNC_B1) ||
                        (phase_reg == PH_SYNC2 && in_byte_reg != SYNC_B2) ||
                        (phase_reg == PH_SYNC3 && in_byte_reg != SYNC_B3))
                    begin
                        phase_next   = PH_HUNT;
                        emit         = 1'b1;
                        emit_is_stat = 1'b1;
                        emit_status  = ST_BAD_SYNC;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                end
                PH_LENH:
                begin
                    len_hi_next = in_byte_reg;
                    crc_next    = crc_fed;
                    phase_next  = PH_LENL;
                end
                PH_LENL:
                begin
                    crc_next = crc_fed;
                    if (total < 16'(HDR_LEN) || total > 16'(MAX_PAYLOAD + HDR_LEN))
                    begin
                        phase_next   = PH_HUNT;
                        emit         = 1'b1;
                        emit_is_stat = 1'b1;
                        emit_status  = ST_BAD_LEN;
                    end
                    else
                    begin
                        left_next  = LEFT_W'(total - 16'(HDR_LEN));
                        phase_next = PH_CMD0;
                    end
                end
                PH_CMD0, PH_CMD1:
                begin
                    if ((phase_reg == PH_CMD0 && in_byte_reg != CMD_B0) ||
                        (phase_reg == PH_CMD1 && in_byte_reg != CMD_B1))
                    begin
                        phase_next   = PH_HUNT;
                        emit         = 1'b1;
                        emit_is_stat = 1'b1;
                        emit_status  = ST_BAD_CMD;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        phase_next = (phase_reg == PH_CMD0) ? PH_CMD1 : PH_ZERO;
                    end
                end
                PH_ZERO:
                begin
                    if (in_byte_reg != 8'h00)
                    begin
                        phase_next   = PH_HUNT;
                        emit         = 1'b1;
                        emit_is_stat = 1'b1;
                        emit_status  = ST_BAD_ZERO;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        phase_next = PH_INDEX;
                    end
                end
                PH_INDEX:
                begin
                    if (in_byte_reg != index_reg)
                    begin
                        phase_next   = PH_HUNT;
                        emit         = 1'b1;
                        emit_is_stat = 1'b1;
                        emit_status  = ST_BAD_IDX;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        // The first packet of a transfer starts with two bytes
                        // that the consumer does not want.
                        skip_next  = (index_reg == 8'd1) ? 2'd2 : 2'd0;
                        phase_next = (left_reg != '0) ? PH_DATA : PH_CRCH;
                    end
                end
                PH_DATA:
                begin
                    crc_next  = crc_fed;
                    left_next = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1))
                    begin
                        phase_next = PH_CRCH;
                    end
                    if (skip_reg != 2'd0)
                    begin
                        skip_next = skip_reg - 2'd1;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_data = in_byte_reg;
                    end
                end
                PH_CRCH:
                begin
                    crc_hi_next = in_byte_reg;
                    phase_next  = PH_CRCL;
                end
                PH_CRCL:
                begin
                    phase_next   = PH_HUNT;
                    emit         = 1'b1;
                    emit_is_stat = 1'b1;
                    if (rx_crc == crc_reg)
                    begin
                        emit_status = ST_OK;
                        index_next  = index_reg + 8'd1;
                    end
                    else
                    begin
                        emit_status = ST_BAD_CRC;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_mode_reg     <= 1'b0;
            in_byte_reg     <= 8'h00;
            phase_reg       <= PH_HUNT;
            left_reg        <= '0;
            crc_reg         <= CRC_INIT;
            index_reg       <= 8'd1;
            len_hi_reg      <= 8'h00;
            crc_hi_reg      <= 8'h00;
            skip_reg        <= 2'd0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= 8'h00;
            out_is_stat_reg <= 1'b0;
            out_status_reg  <= ST_OK;
            out_index_reg   <= 8'h00;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    in_mode_reg <= s_tuser;
                    in_byte_reg <= s_tdata;
                end
            end

            if (process)
            begin
                phase_reg     <= phase_next;
                left_reg      <= left_next;
                crc_reg       <= crc_next;
                index_reg     <= index_next;
                len_hi_reg    <= len_hi_next;
                crc_hi_reg    <= crc_hi_next;
                skip_reg      <= skip_next;
                out_valid_reg <= emit;
                if (emit)
                begin
                    out_data_reg    <= emit_data;
                    out_is_stat_reg <= emit_is_stat;
                    out_status_reg  <= emit_status;
                    // The index is the one of the frame in progress, before it
                    // advances on a good CRC.
                    out_index_reg   <= index_reg;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_is_stat_reg;
    assign m_tdata  = {5'b00000, out_index_reg, out_status_reg, out_data_reg};

endmodule

### rtl/core/ppdc_crc_step.sv
// One byte of CRC-16/MODBUS (reflected), eight shift steps unrolled.
module ppdc_crc_step
    import ppdc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### bench/tb_photo_packet_deframer_crc16.sv
module tb_photo_packet_deframer_crc16;

    import ppdc_pkg::*;

    // Run limits. The slowest legal run is well under four thousand beats, each
    // waiting out long sender gaps and receiver stalls; the limit covers that
    // many times.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Two registers sit between the ports; the tail covers any beat that is
    // still inside the block once the last expected result has arrived.
    localparam int unsigned DRAIN_TAIL  = 6;

    // Parser phases of the predictor, in the order the frame bytes arrive.
    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC1,
        PH_SYNC2,
        PH_SYNC3,
        PH_LENH,
        PH_LENL,
        PH_CMD0,
        PH_CMD1,
        PH_ZERO,
        PH_INDEX,
        PH_DATA,
        PH_CRCH,
        PH_CRCL
    } parse_phase_e;

    // Ways in which the frame builder can spoil a frame.
    typedef enum int {
        FL_NONE,
        FL_SYNC,
        FL_LEN,
        FL_CMD,
        FL_ZERO,
        FL_IDX,
        FL_CRC,
        FL_ABORT
    } frame_flaw_e;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_status;
        status_t    status;
        logic [7:0] packet_index;
    } deframe_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] data_byte, [10:8] status, [18:11] packet_index,
                            // [23:19] zero
    logic        m_tuser;   // [0] is_status

    photo_packet_deframer_crc16 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state. It mirrors the parser of the block and is advanced once
    // for every beat that the block accepts.
    parse_phase_e    ph;
    logic [9:0]      payload_left;
    logic [15:0]     crc_acc;
    logic [7:0]      want_idx;
    logic [7:0]      len_hi;
    logic [7:0]      crc_hi;
    logic [1:0]      skip_left;

    deframe_result_t expected_results[$];

    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     cycle_count;
    int unsigned     errors;
    int unsigned     beats_sent;
    int unsigned     payload_checked;
    int unsigned     status_checked;
    int unsigned     status_seen[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side. Back-pressure is decided at every falling edge so that
    // stalls land on every phase of the frame.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One step of CRC-16/MODBUS: init 0xFFFF, reflected polynomial, LSB first.
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] c_in,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] x);
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (v == x);
        return v;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic st_flag,
                                        input status_t st);
        deframe_result_t r;
        r.data_byte    = d;
        r.is_status    = st_flag;
        r.status       = st;
        r.packet_index = want_idx;
        expected_results.push_back(r);
    endfunction

    // Any header mismatch ends the frame with a status and goes back to hunting.
    function automatic void frame_abort(input status_t st);
        ph = PH_HUNT;
        push_result(8'h00, 1'b1, st);
    endfunction

    // Advances the predicted parser by one accepted beat and queues what the
    // block has to produce for it.
    function automatic void deframe_predict(input logic mode, input logic [7:0] b);
        int total;
        if (mode)
        begin
            // A new transfer drops the frame in progress without a status.
            ph           = PH_HUNT;
            want_idx     = 8'd1;
            payload_left = '0;
            skip_left    = '0;
            return;
        end
        case (ph)
            PH_HUNT:
            begin
                // Anything but the first sync byte is dropped silently.
                if (b == SYNC_B0)
                begin
                    crc_acc = crc16_modbus_byte(CRC_INIT, b);
                    ph      = PH_SYNC1;
                end
            end
            PH_SYNC1, PH_SYNC2, PH_SYNC3:
            begin
                // A wrong tail byte is not taken as a new frame start, even
                // when it is the first sync byte itself.
                if (b != (ph == PH_SYNC1 ? SYNC_B1 : ph == PH_SYNC2 ? SYNC_B2 : SYNC_B3))
                    frame_abort(ST_BAD_SYNC);
                else
                begin
                    crc_acc = crc16_modbus_byte(crc_acc, b);
                    ph      = parse_phase_e'(ph + 1);
                end
            end
            PH_LENH:
            begin
                len_hi  = b;
                crc_acc = crc16_modbus_byte(crc_acc, b);
                ph      = PH_LENL;
            end
            PH_LENL:
            begin
                crc_acc = crc16_modbus_byte(crc_acc, b);
                total   = {len_hi, b};
                if (total < HDR_LEN || total - HDR_LEN > MAX_PAYLOAD)
                    frame_abort(ST_BAD_LEN);
                else
                begin
                    payload_left = 10'(total - HDR_LEN);
                    ph           = PH_CMD0;
                end
            end
            PH_CMD0, PH_CMD1:
            begin
                if (b != (ph == PH_CMD0 ? CMD_B0 : CMD_B1))
                    frame_abort(ST_BAD_CMD);
                else
                begin
                    crc_acc = crc16_modbus_byte(crc_acc, b);
                    ph      = parse_phase_e'(ph + 1);
                end
            end
            PH_ZERO:
            begin
                if (b != 8'h00)
                    frame_abort(ST_BAD_ZERO);
                else
                begin
                    crc_acc = crc16_modbus_byte(crc_acc, b);
                    ph      = PH_INDEX;
                end
            end
            PH_INDEX:
            begin
                if (b != want_idx)
                    frame_abort(ST_BAD_IDX);
                else
                begin
                    crc_acc = crc16_modbus_byte(crc_acc, b);
                    // The first packet of a transfer carries two leading bytes
                    // that the consumer never sees.
                    skip_left = (want_idx == 8'd1) ? 2'd2 : 2'd0;
                    ph        = (payload_left != 0) ? PH_DATA : PH_CRCH;
                end
            end
            PH_DATA:
            begin
                crc_acc      = crc16_modbus_byte(crc_acc, b);
                payload_left = payload_left - 10'd1;
                if (payload_left == 0)
                    ph = PH_CRCH;
                if (skip_left != 0)
                    skip_left = skip_left - 2'd1;
                else
                    push_result(b, 1'b0, ST_OK);
            end
            PH_CRCH:
            begin
                crc_hi = b;
                ph     = PH_CRCL;
            end
            PH_CRCL:
            begin
                ph = PH_HUNT;
                if ({crc_hi, b} == crc_acc)
                begin
                    push_result(8'h00, 1'b1, ST_OK);
                    want_idx = want_idx + 8'd1;
                end
                else
                    push_result(8'h00, 1'b1, ST_BAD_CRC);
            end
            default:
                ph = PH_HUNT;
        endcase
    endfunction

    // Sends one beat: an optional random gap, then valid held until accepted.
    // Called and returning at a falling edge.
    task automatic send_beat(input logic mode, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_predict(mode, b);
        beats_sent++;
        @(negedge clk);
    endtask

    // Holds the sender back until every expected result has come out, then
    // waits out the beats that cause no result.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    // Builds a frame for the current expected index with plen payload bytes
    // and a valid CRC, spoils it as flaw asks, and sends it.
    task automatic send_frame(input int plen, input frame_flaw_e flaw);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          total;
        int          cut;
        int          pos;
        total = plen + HDR_LEN;
        fr = {SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3, 8'(total >> 8), 8'(total),
              CMD_B0, CMD_B1, 8'h00, want_idx};
        for (int i = 0; i < plen; i++)
            fr.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (fr[i])
            crc = crc16_modbus_byte(crc, fr[i]);
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        cut = fr.size();
        case (flaw)
            FL_SYNC:
            begin
                pos = $urandom_range(1, 3);
                fr[pos] = ($urandom_range(2) == 0) ? SYNC_B0 : other_byte(fr[pos]);
                cut = pos + 1;
            end
            FL_LEN:
            begin
                case ($urandom_range(3))
                    0:       total = $urandom_range(0, HDR_LEN - 1);
                    1:       total = HDR_LEN + MAX_PAYLOAD + 1;
                    2:       total = 16'hFFFF;
                    default: total = $urandom_range(HDR_LEN + MAX_PAYLOAD + 1, 16'hFFFF);
                endcase
                fr[4] = 8'(total >> 8);
                fr[5] = 8'(total);
                cut = 6;
            end
            FL_CMD:
            begin
                pos = $urandom_range(6, 7);
                fr[pos] = other_byte(fr[pos]);
                cut = pos + 1;
            end
            FL_ZERO:
            begin
                fr[8] = other_byte(8'h00);
                cut = 9;
            end
            FL_IDX:
            begin
                fr[9] = other_byte(want_idx);
                cut = 10;
            end
            FL_CRC:
            begin
                pos = fr.size() - 1 - $urandom_range(1);
                fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(7));
            end
            FL_ABORT:
                cut = $urandom_range(1, fr.size() - 1);
            default:
                ;
        endcase
        for (int i = 0; i < cut; i++)
            send_beat(1'b0, fr[i]);
        if (flaw == FL_ABORT)
            send_beat(1'b1, 8'($urandom));
    endtask

    // Bytes that are not a sync start vanish while hunting.
    task automatic test_hunt_noise();
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, SYNC_B1);
    endtask

    // The first sync byte in a tail position ends the frame; it does not restart it.
    task automatic test_sync_tail_restart();
        send_beat(1'b0, SYNC_B0);
        send_beat(1'b0, SYNC_B1);
        send_beat(1'b0, SYNC_B0);
    endtask

    // One more than the largest payload is refused right after the low length byte.
    task automatic test_length_over_max();
        int total;
        total = HDR_LEN + MAX_PAYLOAD + 1;
        send_beat(1'b0, SYNC_B0);
        send_beat(1'b0, SYNC_B1);
        send_beat(1'b0, SYNC_B2);
        send_beat(1'b0, SYNC_B3);
        send_beat(1'b0, 8'(total >> 8));
        send_beat(1'b0, 8'(total));
    endtask

    // Packet 1 with no payload goes from the index byte straight to the CRC.
    task automatic test_empty_first_packet();
        send_frame(0, FL_NONE);
    endtask

    // Mostly well-formed frames with random content, mixed with spoiled frames,
    // transfer restarts and line noise, until n_beats beats have gone in.
    task automatic test_random_frames(input int n_beats, input bit with_max_frame);
        int          start;
        int          sel;
        int          plen;
        frame_flaw_e flaw;
        start = beats_sent;
        if (with_max_frame)
            send_frame(MAX_PAYLOAD, FL_NONE);
        while (beats_sent - start < n_beats)
        begin
            sel  = $urandom_range(99);
            plen = ($urandom_range(99) == 0) ? $urandom_range(MAX_PAYLOAD - 8, MAX_PAYLOAD)
                                             : $urandom_range(0, 16);
            if (sel < 55)
                send_frame(plen, FL_NONE);
            else if (sel < 80)
            begin
                flaw = frame_flaw_e'($urandom_range(FL_SYNC, FL_ABORT));
                send_frame(plen, flaw);
            end
            else if (sel < 88)
            begin
                // New transfer followed by a short first packet of at most three payload
                // bytes, so that sometimes fewer than two are there to be dropped.
                send_beat(1'b1, 8'($urandom));
                send_frame($urandom_range(0, 3), FL_NONE);
            end
            else
                repeat ($urandom_range(1, 6)) send_beat(1'b0, 8'($urandom));
        end
    endtask

    // Every result the block hands over is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        deframe_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("Result with nothing expected: data_byte %0h is_status %0d status %0d",
                       m_tdata[7:0], m_tuser, m_tdata[10:8]);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[7:0] !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tuser !== want.is_status)
                begin
                    $error("is_status: expected %0d, got %0d", want.is_status, m_tuser);
                    errors++;
                end
                if (m_tdata[10:8] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[10:8]);
                    errors++;
                end
                if (m_tdata[18:11] !== want.packet_index)
                begin
                    $error("packet_index: expected %0d, got %0d",
                           want.packet_index, m_tdata[18:11]);
                    errors++;
                end
                if (want.is_status)
                begin
                    status_checked++;
                    status_seen[want.status]++;
                end
                else
                    payload_checked++;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = 1'b0;
        errors        = 0;
        beats_sent    = 0;
        payload_checked = 0;
        status_checked  = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        send_idle_pct = 36;
        recv_idle_pct = 74;

        // Predictor starts where the block does after reset.
        ph           = PH_HUNT;
        payload_left = '0;
        crc_acc      = CRC_INIT;
        want_idx     = 8'd1;
        len_hi       = '0;
        crc_hi       = '0;
        skip_left    = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Sender gaps light, receiver stalls heavy.
        test_hunt_noise();
        test_sync_tail_restart();
        test_length_over_max();
        test_empty_first_packet();
        drain_results();
        test_random_frames(400, 1'b0);
        drain_results();

        // Sender gaps heavy, receiver stalls light.
        send_idle_pct = 74;
        recv_idle_pct = 36;
        test_random_frames(400, 1'b0);
        drain_results();

        // Full rate in both directions.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(450, 1'b1);
        drain_results();

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("Sent %0d beats; checked %0d payload bytes and %0d frame statuses",
                 beats_sent, payload_checked, status_checked);
        $display("Statuses ok/sync/cmd/zero/idx/len/crc: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_BAD_SYNC], status_seen[ST_BAD_CMD],
                 status_seen[ST_BAD_ZERO], status_seen[ST_BAD_IDX], status_seen[ST_BAD_LEN],
                 status_seen[ST_BAD_CRC]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
